>>> sv/integer_to_ascii_radix_top_defines.svh
// assertion helpers shared by the rtl
`ifndef INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define ITOA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that must hold in the clock cycle after the antecedent
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/itoa_pkg.sv
package itoa_pkg;

	localparam int VALUE_W      = 64;
	localparam int RADIX_W      = 5;
	localparam int CHAR_W       = 7;
	localparam int VALUE_WIDTH_DEF = 64;
	localparam int NARROW_WIDTH = 32;
	localparam int MAX_CHARS    = 64;
	localparam int DIGIT_W      = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_FETCH,
		ST_SEND
	} itoa_state_t;

	function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		begin
			unique case (d)
				4'h0: c = 7'h30;
				4'h1: c = 7'h31;
				4'h2: c = 7'h32;
				4'h3: c = 7'h33;
				4'h4: c = 7'h34;
				4'h5: c = 7'h35;
				4'h6: c = 7'h36;
				4'h7: c = 7'h37;
				4'h8: c = 7'h38;
				4'h9: c = 7'h39;
				4'hA: c = 7'h41;
				4'hB: c = 7'h42;
				4'hC: c = 7'h43;
				4'hD: c = 7'h44;
				4'hE: c = 7'h45;
				4'hF: c = 7'h46;
				default: c = CHAR_NONE;
			endcase
			return c;
		end
	endfunction

endpackage

>>> sv/itoa_num_if.sv
interface itoa_num_if import itoa_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [RADIX_W-1:0]        radix;
	logic                      narrow_mode;

	modport source (output valid, value, radix, narrow_mode, input ready);
	modport sink (input valid, value, radix, narrow_mode, output ready);
endinterface

>>> sv/itoa_text_if.sv
interface itoa_text_if import itoa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;
	logic              is_empty;

	modport source (output valid, char_code, is_last, is_empty, input ready);
	modport sink (input valid, char_code, is_last, is_empty, output ready);
endinterface

>>> sv/integer_to_ascii_radix_top.sv
// integer to ascii conversion in radix 2 to 16
// num channel: one beat holds value, radix and narrow_mode; text channel: one beat per
// character, most significant digit first, uppercase letters, is_last on the final one.
// radix 10 with a negative value sends a leading minus and the magnitude; other radices
// send the two's complement pattern (32 bits in narrow mode, VALUE_WIDTH bits otherwise).
// a radix outside 2..16 gives a single beat with is_empty and is_last set, char_code zero.
// one shared divide unit retires 4 dividend bits a cycle: each digit is a divide pass
// over every nibble of the value, then a store of the remainder to the digit memory;
// each digit character is then a digit memory read, then the beat, held through any stall.
// num.ready is high only while idle: one item is converted at a time.
// when the receiver stalls, the current beat holds on the text channel until taken.
// reset returns the sequencer to idle; a conversion in flight is dropped.
`include "integer_to_ascii_radix_top_defines.svh"

module integer_to_ascii_radix_top import itoa_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	itoa_num_if.sink    num,
	itoa_text_if.source text
);

	localparam int NCHUNK = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int PW     = NCHUNK * DIGIT_W;
	localparam int STEP_W = $clog2(NCHUNK);
	localparam int CNT_W  = $clog2(MAX_CHARS + 1);
	localparam int ADDR_W = $clog2(MAX_CHARS);

	itoa_state_t state_q, state_d;

	logic [CNT_W-1:0]   cnt_q;
	logic [STEP_W-1:0]  step_q;
	logic               minus_q;
	logic               empty_q;

	logic [PW-1:0]      work_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [DIGIT_W-1:0] rd_q;

	logic [DIGIT_W-1:0] dig_mem [MAX_CHARS];

	logic                   num_fire;
	logic                   radix_ok;
	logic                   sign_bit;
	logic                   use_neg;
	logic [VALUE_WIDTH-1:0] raw_w;
	logic [VALUE_WIDTH-1:0] neg_full;
	logic [VALUE_WIDTH-1:0] neg_w;
	logic [VALUE_WIDTH-1:0] mag_w;

	logic [DIGIT_W-1:0] qnib;
	logic [DIGIT_W-1:0] rem_next;
	logic               step_last;
	logic               div_done;
	logic               send_last;
	logic [ADDR_W-1:0]  rd_addr;

	// input decode
	always_comb begin
		num_fire = num.valid && num.ready;
		radix_ok = (num.radix >= RADIX_MIN) && (num.radix <= RADIX_MAX);
		raw_w    = num.narrow_mode ? VALUE_WIDTH'(num.value[NARROW_WIDTH-1:0])
			: num.value[VALUE_WIDTH-1:0];
		sign_bit = num.narrow_mode ? num.value[NARROW_WIDTH-1] : num.value[VALUE_WIDTH-1];
		use_neg  = sign_bit && (num.radix == RADIX_DEC);
		neg_full = VALUE_WIDTH'(~raw_w + 1'b1);
		neg_w    = num.narrow_mode ? VALUE_WIDTH'(neg_full[NARROW_WIDTH-1:0]) : neg_full;
		mag_w    = use_neg ? neg_w : raw_w;
	end

	// shared divide step: four restoring compare/subtract steps on the top nibble
	always_comb begin
		logic [DIGIT_W-1:0] r;
		logic [DIGIT_W:0]   t;
		r    = rem_q;
		qnib = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {r, work_q[PW-DIGIT_W+i]};
			if (t >= radix_q) begin
				qnib[i] = 1'b1;
				r       = DIGIT_W'(t - radix_q);
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		rem_next = r;
	end

	always_comb begin
		step_last = (step_q == STEP_W'(NCHUNK - 1));
		div_done  = (work_q == '0) || (cnt_q == CNT_W'(MAX_CHARS - 1));
		send_last = empty_q || (!minus_q && (cnt_q == CNT_W'(1)));
		rd_addr   = ADDR_W'(cnt_q - 1'b1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (num_fire) state_d = radix_ok ? ST_DIV : ST_SEND;
			end
			ST_DIV: begin
				if (step_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				if (div_done) state_d = minus_q ? ST_SEND : ST_FETCH;
				else state_d = ST_DIV;
			end
			ST_FETCH: begin
				state_d = ST_SEND;
			end
			ST_SEND: begin
				if (text.ready) state_d = send_last ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		num.ready      = (state_q == ST_IDLE);
		text.valid     = (state_q == ST_SEND);
		text.is_empty  = empty_q;
		text.is_last   = send_last;
		if (empty_q) text.char_code = CHAR_NONE;
		else if (minus_q) text.char_code = CHAR_MINUS;
		else text.char_code = digit_code(rd_q);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			minus_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (num_fire) begin
						cnt_q   <= '0;
						step_q  <= '0;
						minus_q <= use_neg && radix_ok;
						empty_q <= !radix_ok;
					end
				end
				ST_DIV: begin
					step_q <= STEP_W'(step_q + 1'b1);
				end
				ST_STORE: begin
					cnt_q  <= CNT_W'(cnt_q + 1'b1);
					step_q <= '0;
				end
				ST_FETCH: begin
				end
				ST_SEND: begin
					// minus goes first, then digits count down
					if (text.ready) begin
						if (minus_q) minus_q <= 1'b0;
						else if (!empty_q) cnt_q <= CNT_W'(cnt_q - 1'b1);
						if (send_last) empty_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (num_fire) begin
					work_q  <= PW'(mag_w);
					rem_q   <= '0;
					radix_q <= num.radix;
				end
			end
			ST_DIV: begin
				work_q <= {work_q[PW-DIGIT_W-1:0], qnib};
				rem_q  <= rem_next;
			end
			ST_STORE: begin
				rem_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// digit store, least significant digit at address zero
	always_ff @(posedge clk) begin
		if (state_q == ST_STORE) dig_mem[cnt_q[ADDR_W-1:0]] <= rem_q;
		if (state_q == ST_FETCH) rd_q <= dig_mem[rd_addr];
	end

	`ITOA_ASSERT(a_rem_below_radix, (state_q != ST_STORE) || (rem_q < radix_q), "remainder not below radix")
	`ITOA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_CHARS), "digit count past capacity")
	`ITOA_ASSERT(a_empty_is_last, !(text.valid && text.is_empty) || text.is_last, "empty beat not last")
	`ITOA_ASSERT(a_minus_radix10, !(text.valid && minus_q) || ((radix_q == RADIX_DEC) && !text.is_last), "bad minus beat")
	`ITOA_ASSERT_NEXT(a_last_to_idle, text.valid && text.ready && text.is_last, num.ready, "no return to idle after last beat")

endmodule
